FILE: design/sthm_pkg.sv
// Shared constants, types and index helpers for the tensor harmonic-mean block.
package sthm_pkg;

    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int WEIGHT_BITS = 16;
    localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
    localparam int LIMB_W = 32;
    localparam int NCOMP = 6;

    typedef struct packed {
        logic [63:0] xx_xy;
        logic [63:0] xz_yy;
        logic [63:0] yz_zz;
        logic        singular;
    } face_t;

    // storage slot of element (i,j) of a symmetric 3x3 tensor: xx xy xz yy yz zz
    function automatic int sym_slot(input int i, input int j);
        int lo;
        int hi;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        if (lo == 0) begin
            return hi;
        end else if (lo == 1) begin
            return 2 + hi;
        end else begin
            return 5;
        end
    endfunction

    function automatic int slot_row(input int s);
        case (s)
            0, 1, 2: return 0;
            3, 4:    return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int slot_col(input int s);
        case (s)
            0:       return 0;
            1, 3:    return 1;
            default: return 2;
        endcase
    endfunction

endpackage

FILE: design/symmetric_tensor_harmonic_mean.sv
// Throughput: one item per cycle unless the skid entry is full; the quotient is formed
// one bit per stage over COMPONENT_WIDTH divider stages, with limb products registered
// ahead of each sum.
// An output register plus one skid entry let input flow on while a result waits.
// Reset (synchronous, aresetn low) clears all valid bits; data registers are not reset.
module symmetric_tensor_harmonic_mean #(
    parameter int COMPONENT_WIDTH = sthm_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_near_xx_xy,
    input  logic [63:0] s_near_xz_yy,
    input  logic [63:0] s_near_yz_zz,
    input  logic [63:0] s_far_xx_xy,
    input  logic [63:0] s_far_xz_yy,
    input  logic [63:0] s_far_yz_zz,
    input  logic [16:0] s_weight,
    input  logic        s_is_coupled,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_face_xx_xy,
    output logic [63:0] m_face_xz_yy,
    output logic [63:0] m_face_yz_zz,
    output logic        m_singular
);
    localparam int CW  = COMPONENT_WIDTH;
    localparam int WB  = sthm_pkg::WEIGHT_BITS;
    localparam int MW  = CW + WB + 2;
    localparam int CFW = 2 * MW + 1;
    localparam int DW  = CFW + MW + 2;
    localparam int AW2 = 2 * CW + 1;
    localparam int ADW = AW2 + CW + 2;
    localparam int TW  = CW + CFW + 2;
    localparam int SW  = TW + CW + 2;
    localparam int NW  = SW + WB;
    localparam int QW  = CW + 1;
    localparam int NST = 12 + CW;
    localparam int LD  = NST - 1;

    logic en;
    logic [NST-1:0] vld_reg;

    logic signed [CW-1:0] a_in [6];
    logic signed [CW-1:0] b_in [6];
    logic signed [CW-1:0] a_pipe_reg [NST][6];
    logic signed [CW-1:0] b_pipe_reg [5][6];
    logic                 cp_pipe_reg [NST];
    logic [WB:0]          w_reg;
    logic [WB:0]          wn;
    logic signed [MW-1:0] m_next [6];
    logic signed [MW-1:0] m_pipe_reg [1:4][6];

    logic signed [2*MW-1:0] cp_pos [6];
    logic signed [2*MW-1:0] cp_neg [6];
    logic signed [2*CW-1:0] ap_pos [3];
    logic signed [2*CW-1:0] ap_neg [3];
    logic signed [2*CW-1:0] bp_pos [3];
    logic signed [2*CW-1:0] bp_neg [3];
    logic signed [CFW-1:0]  cm_reg [6];
    logic signed [AW2-1:0]  ca_reg [3];
    logic signed [AW2-1:0]  cb_reg [3];

    logic signed [MW+CFW-1:0] dm_p [3];
    logic signed [CW+AW2-1:0] da_p [3];
    logic signed [CW+AW2-1:0] db_p [3];
    logic signed [CW+CFW-1:0] tp [9][3];
    logic signed [DW-1:0]     dm_sum;
    logic signed [ADW-1:0]    da_sum;
    logic signed [ADW-1:0]    db_sum;
    logic signed [DW-1:0]     detm_pipe_reg [7:10];
    logic                     sing_pipe_reg [7:NST-1];
    logic signed [TW-1:0]     t_reg [9];

    logic signed [TW+CW-1:0] sp [6][3];
    logic signed [SW-1:0]    s_reg [6];

    logic [NW-1:0] rem_pipe_reg [11:NST-1][6];
    logic [CW-1:0] q_pipe_reg   [11:NST-1][6];
    logic          neg_pipe_reg [11:NST-1][6];
    logic          sat_pipe_reg [11:NST-1][6];
    logic [DW-1:0] d_pipe_reg   [11:NST-1];
    logic [DW-1:0] d_abs;

    logic [CW-1:0]      res [6];
    sthm_pkg::face_t    fin;
    sthm_pkg::face_t    out_reg;
    sthm_pkg::face_t    skid_reg;
    logic               m_valid_reg;
    logic               skid_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    assign a_in[0] = s_near_xx_xy[32 +: CW];
    assign a_in[1] = s_near_xx_xy[0 +: CW];
    assign a_in[2] = s_near_xz_yy[32 +: CW];
    assign a_in[3] = s_near_xz_yy[0 +: CW];
    assign a_in[4] = s_near_yz_zz[32 +: CW];
    assign a_in[5] = s_near_yz_zz[0 +: CW];
    assign b_in[0] = s_far_xx_xy[32 +: CW];
    assign b_in[1] = s_far_xx_xy[0 +: CW];
    assign b_in[2] = s_far_xz_yy[32 +: CW];
    assign b_in[3] = s_far_xz_yy[0 +: CW];
    assign b_in[4] = s_far_yz_zz[32 +: CW];
    assign b_in[5] = s_far_yz_zz[0 +: CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // M = (1-w)*far + w*near
    assign wn = sthm_pkg::WEIGHT_ONE - w_reg;
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            m_next[k] = MW'($signed({1'b0, wn})) * MW'(b_pipe_reg[0][k])
                      + MW'($signed({1'b0, w_reg})) * MW'(a_pipe_reg[0][k]);
        end
    end

    always_comb begin
        dm_sum = DW'(dm_p[0]) + DW'(dm_p[1]) + DW'(dm_p[2]);
        da_sum = ADW'(da_p[0]) + ADW'(da_p[1]) + ADW'(da_p[2]);
        db_sum = ADW'(db_p[0]) + ADW'(db_p[1]) + ADW'(db_p[2]);
    end

    assign d_abs = detm_pipe_reg[10][DW-1] ? DW'(-detm_pipe_reg[10]) : DW'(detm_pipe_reg[10]);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_pipe_reg[0]  <= a_in;
            b_pipe_reg[0]  <= b_in;
            cp_pipe_reg[0] <= s_is_coupled;
            w_reg <= (s_weight > sthm_pkg::WEIGHT_ONE) ? sthm_pkg::WEIGHT_ONE : s_weight;
            for (int k = 1; k < NST; k++) begin
                a_pipe_reg[k]  <= a_pipe_reg[k-1];
                cp_pipe_reg[k] <= cp_pipe_reg[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                b_pipe_reg[k] <= b_pipe_reg[k-1];
            end
            m_pipe_reg[1] <= m_next;
            for (int k = 2; k <= 4; k++) begin
                m_pipe_reg[k] <= m_pipe_reg[k-1];
            end
            for (int s = 0; s < 6; s++) begin
                cm_reg[s] <= CFW'(cp_pos[s]) - CFW'(cp_neg[s]);
            end
            for (int c = 0; c < 3; c++) begin
                ca_reg[c] <= AW2'(ap_pos[c]) - AW2'(ap_neg[c]);
                cb_reg[c] <= AW2'(bp_pos[c]) - AW2'(bp_neg[c]);
            end
            detm_pipe_reg[7] <= dm_sum;
            sing_pipe_reg[7] <= (dm_sum == '0) || (da_sum == '0) || (db_sum == '0);
            for (int k = 0; k < 9; k++) begin
                t_reg[k] <= TW'(tp[k][0]) + TW'(tp[k][1]) + TW'(tp[k][2]);
            end
            for (int k = 8; k <= 10; k++) begin
                detm_pipe_reg[k] <= detm_pipe_reg[k-1];
            end
            for (int k = 8; k < NST; k++) begin
                sing_pipe_reg[k] <= sing_pipe_reg[k-1];
            end
            for (int s = 0; s < 6; s++) begin
                s_reg[s] <= SW'(sp[s][0]) + SW'(sp[s][1]) + SW'(sp[s][2]);
            end
            d_pipe_reg[11] <= d_abs;
            for (int k = 12; k < NST; k++) begin
                d_pipe_reg[k] <= d_pipe_reg[k-1];
            end
        end
    end

    // cofactors of M (all six), and first-row cofactors of near and far
    for (genvar s = 0; s < 6; s++) begin : g_cof
        localparam int R  = sthm_pkg::slot_row(s);
        localparam int C  = sthm_pkg::slot_col(s);
        localparam int R1 = (R + 1) % 3;
        localparam int R2 = (R + 2) % 3;
        localparam int C1 = (C + 1) % 3;
        localparam int C2 = (C + 2) % 3;
        sthm_mul #(.AW(MW), .BW(MW)) u_pos (
            .aclk(aclk), .en(en),
            .a(m_pipe_reg[1][sthm_pkg::sym_slot(R1, C1)]),
            .b(m_pipe_reg[1][sthm_pkg::sym_slot(R2, C2)]),
            .p(cp_pos[s])
        );
        sthm_mul #(.AW(MW), .BW(MW)) u_neg (
            .aclk(aclk), .en(en),
            .a(m_pipe_reg[1][sthm_pkg::sym_slot(R1, C2)]),
            .b(m_pipe_reg[1][sthm_pkg::sym_slot(R2, C1)]),
            .p(cp_neg[s])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_row0
        localparam int C1 = (c + 1) % 3;
        localparam int C2 = (c + 2) % 3;
        sthm_mul #(.AW(CW), .BW(CW)) u_ap (
            .aclk(aclk), .en(en),
            .a(a_pipe_reg[1][sthm_pkg::sym_slot(1, C1)]),
            .b(a_pipe_reg[1][sthm_pkg::sym_slot(2, C2)]),
            .p(ap_pos[c])
        );
        sthm_mul #(.AW(CW), .BW(CW)) u_an (
            .aclk(aclk), .en(en),
            .a(a_pipe_reg[1][sthm_pkg::sym_slot(1, C2)]),
            .b(a_pipe_reg[1][sthm_pkg::sym_slot(2, C1)]),
            .p(ap_neg[c])
        );
        sthm_mul #(.AW(CW), .BW(CW)) u_bp (
            .aclk(aclk), .en(en),
            .a(b_pipe_reg[1][sthm_pkg::sym_slot(1, C1)]),
            .b(b_pipe_reg[1][sthm_pkg::sym_slot(2, C2)]),
            .p(bp_pos[c])
        );
        sthm_mul #(.AW(CW), .BW(CW)) u_bn (
            .aclk(aclk), .en(en),
            .a(b_pipe_reg[1][sthm_pkg::sym_slot(1, C2)]),
            .b(b_pipe_reg[1][sthm_pkg::sym_slot(2, C1)]),
            .p(bp_neg[c])
        );
        // determinants by first-row expansion
        sthm_mul #(.AW(MW), .BW(CFW)) u_dm (
            .aclk(aclk), .en(en),
            .a(m_pipe_reg[4][c]), .b(cm_reg[c]), .p(dm_p[c])
        );
        sthm_mul #(.AW(CW), .BW(AW2)) u_da (
            .aclk(aclk), .en(en),
            .a(a_pipe_reg[4][c]), .b(ca_reg[c]), .p(da_p[c])
        );
        sthm_mul #(.AW(CW), .BW(AW2)) u_db (
            .aclk(aclk), .en(en),
            .a(b_pipe_reg[4][c]), .b(cb_reg[c]), .p(db_p[c])
        );
    end

    // T = far * adj(M); adj(M) is symmetric since M is
    for (genvar i = 0; i < 3; i++) begin : g_ti
        for (genvar j = 0; j < 3; j++) begin : g_tj
            for (genvar k = 0; k < 3; k++) begin : g_tk
                sthm_mul #(.AW(CW), .BW(CFW)) u_t (
                    .aclk(aclk), .en(en),
                    .a(b_pipe_reg[4][sthm_pkg::sym_slot(i, k)]),
                    .b(cm_reg[sthm_pkg::sym_slot(k, j)]),
                    .p(tp[3*i+j][k])
                );
            end
        end
    end

    // S = T * near, upper triangle only
    for (genvar s = 0; s < 6; s++) begin : g_s
        localparam int R = sthm_pkg::slot_row(s);
        localparam int C = sthm_pkg::slot_col(s);
        for (genvar k = 0; k < 3; k++) begin : g_sk
            sthm_mul #(.AW(TW), .BW(CW)) u_s (
                .aclk(aclk), .en(en),
                .a(t_reg[3*R+k]),
                .b(a_pipe_reg[7][sthm_pkg::sym_slot(k, C)]),
                .p(sp[s][k])
            );
        end
    end

    // magnitudes, signs and the overflow test ahead of the divider
    for (genvar s = 0; s < 6; s++) begin : g_pre
        logic [SW-1:0] s_mag;
        logic [NW-1:0] n_val;
        assign s_mag = s_reg[s][SW-1] ? SW'(-s_reg[s]) : SW'(s_reg[s]);
        assign n_val = NW'(s_mag) << WB;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_pipe_reg[11][s] <= n_val;
                q_pipe_reg[11][s]   <= '0;
                neg_pipe_reg[11][s] <= s_reg[s][SW-1] ^ detm_pipe_reg[10][DW-1];
                sat_pipe_reg[11][s] <= {1'b0, n_val} >= ((NW + 1)'(d_abs) << CW);
            end
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar k = 12; k < NST; k++) begin : g_div
        localparam int BIT = LD - k;
        for (genvar s = 0; s < 6; s++) begin : g_lane
            logic [NW-1:0] trial;
            logic          take;
            assign trial = NW'(d_pipe_reg[k-1]) << BIT;
            assign take  = rem_pipe_reg[k-1][s] >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_pipe_reg[k][s] <= take ? rem_pipe_reg[k-1][s] - trial
                                               : rem_pipe_reg[k-1][s];
                    q_pipe_reg[k][s]   <= q_pipe_reg[k-1][s] | (CW'(take) << BIT);
                    neg_pipe_reg[k][s] <= neg_pipe_reg[k-1][s];
                    sat_pipe_reg[k][s] <= sat_pipe_reg[k-1][s];
                end
            end
        end
    end

    // round half away from zero, clamp, apply sign, select pass-through or zero
    always_comb begin
        logic          rnd;
        logic [QW-1:0] qr;
        logic [QW-1:0] lim;
        logic [QW-1:0] qs;
        logic [CW-1:0] mag;
        for (int s = 0; s < 6; s++) begin
            rnd = {rem_pipe_reg[LD][s], 1'b0} >= (NW + 1)'(d_pipe_reg[LD]);
            qr  = QW'(q_pipe_reg[LD][s]) + QW'(rnd);
            lim = neg_pipe_reg[LD][s] ? (QW'(1) << (CW - 1)) : (QW'(1) << (CW - 1)) - QW'(1);
            qs  = (sat_pipe_reg[LD][s] || (qr > lim)) ? lim : qr;
            mag = qs[CW-1:0];
            if (!cp_pipe_reg[LD]) begin
                res[s] = a_pipe_reg[LD][s];
            end else if (sing_pipe_reg[LD]) begin
                res[s] = '0;
            end else begin
                res[s] = neg_pipe_reg[LD][s] ? -mag : mag;
            end
        end
        fin.xx_xy    = {32'(res[0]), 32'(res[1])};
        fin.xz_yy    = {32'(res[2]), 32'(res[3])};
        fin.yz_zz    = {32'(res[4]), 32'(res[5])};
        fin.singular = cp_pipe_reg[LD] && sing_pipe_reg[LD];
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (en && vld_reg[LD]) begin
                skid_v_reg <= 1'b1;
            end
        end else if (skid_v_reg) begin
            m_valid_reg <= 1'b1;
            skid_v_reg  <= 1'b0;
        end else begin
            m_valid_reg <= vld_reg[LD];
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (en && vld_reg[LD]) begin
                skid_reg <= fin;
            end
        end else if (skid_v_reg) begin
            out_reg <= skid_reg;
        end else begin
            out_reg <= fin;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_face_xx_xy = out_reg.xx_xy;
    assign m_face_xz_yy = out_reg.xz_yy;
    assign m_face_yz_zz = out_reg.yz_zz;
    assign m_singular   = out_reg.singular;

endmodule

FILE: design/sthm_mul.sv
// Two-stage signed multiplier built from registered 33x33 limb products.
module sthm_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    localparam int LW = sthm_pkg::LIMB_W;
    localparam int LA = (AW + LW - 1) / LW;
    localparam int LB = (BW + LW - 1) / LW;
    localparam int XW = LW * (LA + LB) + 2;

    logic signed [LW*LA-1:0]  ax;
    logic signed [LW*LB-1:0]  bx;
    logic signed [LW:0]       la [LA];
    logic signed [LW:0]       lb [LB];
    logic signed [2*LW+1:0]   pp_reg [LA][LB];
    logic signed [XW-1:0]     acc;
    logic signed [AW+BW-1:0]  p_reg;

    assign ax = (LW * LA)'(a);
    assign bx = (LW * LB)'(b);

    // low limbs are unsigned, the top limb carries the sign
    always_comb begin
        for (int i = 0; i < LA; i++) begin
            la[i] = (i == LA - 1) ? {ax[LW*i+LW-1], ax[LW*i +: LW]} : {1'b0, ax[LW*i +: LW]};
        end
        for (int j = 0; j < LB; j++) begin
            lb[j] = (j == LB - 1) ? {bx[LW*j+LW-1], bx[LW*j +: LW]} : {1'b0, bx[LW*j +: LW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    pp_reg[i][j] <= la[i] * lb[j];
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < LA; i++) begin
            for (int j = 0; j < LB; j++) begin
                acc = acc + (XW'(pp_reg[i][j]) <<< (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= acc[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

FILE: design/sthm_checker.sv
// Port-level checks for the tensor harmonic-mean block, bound to the top level.
module sthm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [63:0] s_near_xx_xy,
    input logic [63:0] s_near_xz_yy,
    input logic [63:0] s_near_yz_zz,
    input logic [63:0] s_far_xx_xy,
    input logic [63:0] s_far_xz_yy,
    input logic [63:0] s_far_yz_zz,
    input logic [16:0] s_weight,
    input logic        s_is_coupled,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_face_xx_xy,
    input logic [63:0] m_face_xz_yy,
    input logic [63:0] m_face_yz_zz,
    input logic        m_singular
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_face_xx_xy) && $stable(m_face_xz_yy)
                                && $stable(m_face_yz_zz) && $stable(m_singular))
        else $error("result item changed while stalled");

    // singular faces always come out as a zero tensor
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_face_xx_xy == 64'd0 && m_face_xz_yy == 64'd0
                                  && m_face_yz_zz == 64'd0)
        else $error("singular item with nonzero tensor");

    // input stalls only once the output register and the skid entry are both full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind symmetric_tensor_harmonic_mean sthm_checker u_sthm_checker (.*);
